// ===== rtl/rau_pkg.sv =====
// package for the rational arithmetic unit: request/result types and codes
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
        logic [1:0]         order;
    } rau_res_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic mul_step;  // one product pass
        logic form;      // combine products, check range
        logic gcd_step;  // one euclid/division bit step
        logic gcd_next;  // advance euclid after a remainder is ready
        logic div_start; // start dividing by the gcd
        logic fin;       // build result register
    } rau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic early;     // result known without reduction
        logic div_done;  // current bit-serial division finished
        logic gcd_zero;  // euclid remainder is zero
        logic red_phase; // numerator division by the gcd in progress
    } rau_sts_t;

endpackage

// ===== rtl/rau_ctrl.sv =====
// controller sequencing the rational unit datapath
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  rau_sts_t sts,
    output rau_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_FORM = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_RED  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } rau_state_t;

    rau_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // last pass leaves the denominator product on the multiplier
                if (sts.mul_done)
                    state_next = S_FORM;
                else
                    cmd.mul_step = 1'b1;
            end
            S_FORM:
            begin
                cmd.form = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.early)
                    state_next = S_FIN;
                else if (sts.div_done)
                begin
                    if (sts.gcd_zero)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = S_RED;
                    end
                    else
                        cmd.gcd_next = 1'b1;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_RED:
            begin
                if (sts.div_done)
                begin
                    if (sts.red_phase)
                        cmd.div_start = 1'b1;
                    else
                        state_next = S_FIN;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/rau_dp.sv =====
// datapath: shared 32x32 multiplier, range check and bit-serial euclid divider
module rau_dp
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic     clk,
    input  rau_req_t req,
    input  rau_cmd_t cmd,
    output rau_sts_t sts,
    output rau_res_t res
);

    localparam int CW = $clog2(WORD_BITS + 1);
    localparam logic signed [64:0] WMAX = (65'sd1 <<< (WORD_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] WMIN = -WMAX - 65'sd1;

    rau_req_t           req_reg;
    logic [1:0]         mcnt_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic               early_reg;
    logic [1:0]         est_reg, eord_reg;
    logic               neg_reg;
    logic [WORD_BITS-1:0] y_reg, g_reg, mag_reg, den_reg, qn_reg;
    // serial divider
    logic [WORD_BITS-1:0] dq_reg, dr_reg, dd_reg;
    logic [CW-1:0]        dcnt_reg;
    logic [1:0]           phase_reg; // 0 euclid, 1 numerator, 2 denominator
    rau_res_t             res_reg;

    // one 32x32 signed product per cycle
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    always_comb
    begin
        case (mcnt_reg)
            2'd0:
            begin
                ma = {req_reg.a_num[31], req_reg.a_num};
                mb = $signed({2'b00, req_reg.b_den});
            end
            2'd1:
            begin
                ma = $signed({2'b00, req_reg.a_den});
                mb = {req_reg.b_num[31], req_reg.b_num};
            end
            2'd2:
            begin
                ma = {req_reg.a_num[31], req_reg.a_num};
                mb = {req_reg.b_num[31], req_reg.b_num};
            end
            default: begin ma = $signed({2'b00, req_reg.a_den});
                           mb = $signed({2'b00, req_reg.b_den}); end
        endcase
        mp = ma * mb;
    end

    // combine products: p0 an*bd, p1 ad*bn, p2 an*bn, mcnt3 -> ad*bd in mp
    logic signed [64:0] fnum, fden;
    logic [2:0] c;
    always_comb
    begin
        c = req_reg.command;
        fden = $signed(mp[64:0]);
        case (c)
            CMD_ADD: fnum = $signed({p0_reg[63], p0_reg}) + $signed({p1_reg[63], p1_reg});
            CMD_SUB: fnum = $signed({p0_reg[63], p0_reg}) - $signed({p1_reg[63], p1_reg});
            CMD_MUL: fnum = $signed({p2_reg[63], p2_reg});
            default:
            begin
                fnum = $signed({p0_reg[63], p0_reg});
                fden = $signed({p1_reg[63], p1_reg});
                if (p1_reg < 0)
                begin
                    fnum = -fnum;
                    fden = -fden;
                end
            end
        endcase
    end

    logic [WORD_BITS:0] dtrial;
    assign dtrial = {dr_reg, dq_reg[WORD_BITS-1]} - {1'b0, dd_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req;
            mcnt_reg <= 2'd0;
        end
        if (cmd.mul_step)
        begin
            mcnt_reg <= mcnt_reg + 2'd1;
            case (mcnt_reg)
                2'd0:    p0_reg <= mp[63:0];
                2'd1:    p1_reg <= mp[63:0];
                2'd2:    p2_reg <= mp[63:0];
                default: ;
            endcase
        end
        if (cmd.form)
        begin
            early_reg <= 1'b1;
            est_reg   <= ST_OK;
            eord_reg  <= ORD_LESS;
            if (c == CMD_CMP)
                eord_reg <= (p0_reg < p1_reg) ? ORD_LESS :
                            (p0_reg == p1_reg) ? ORD_EQUAL : ORD_GREATER;
            else if (c > CMD_CMP)
                ;
            else if (req_reg.a_den == '0 || req_reg.b_den == '0 ||
                     (c == CMD_DIV && req_reg.b_num == '0))
                est_reg <= ST_DIVZERO;
            else if (fnum < WMIN || fnum > WMAX || fden > WMAX)
                est_reg <= ST_OVERFLOW;
            else
            begin
                early_reg <= (fnum == 0);
                neg_reg   <= fnum[64];
                mag_reg   <= fnum[64] ? WORD_BITS'(-fnum) : WORD_BITS'(fnum);
                den_reg   <= WORD_BITS'(fden);
                y_reg     <= WORD_BITS'(fden);
                // first euclid step: x mod y
                dq_reg    <= fnum[64] ? WORD_BITS'(-fnum) : WORD_BITS'(fnum);
                dd_reg    <= WORD_BITS'(fden);
                dr_reg    <= '0;
                dcnt_reg  <= '0;
                phase_reg <= 2'd0;
            end
        end
        if (cmd.gcd_step)
        begin
            dq_reg <= {dq_reg[WORD_BITS-2:0], ~dtrial[WORD_BITS]};
            dr_reg <= dtrial[WORD_BITS] ? {dr_reg[WORD_BITS-2:0], dq_reg[WORD_BITS-1]}
                                        : dtrial[WORD_BITS-1:0];
            dcnt_reg <= dcnt_reg + CW'(1);
        end
        if (cmd.gcd_next)
        begin
            y_reg    <= dr_reg;
            dq_reg   <= y_reg;
            dd_reg   <= dr_reg;
            dr_reg   <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_start)
        begin
            dr_reg   <= '0;
            dcnt_reg <= '0;
            if (phase_reg == 2'd0)
            begin
                g_reg     <= y_reg;
                dq_reg    <= mag_reg;
                dd_reg    <= y_reg;
                phase_reg <= 2'd1;
            end
            else
            begin
                qn_reg    <= dq_reg;
                dq_reg    <= den_reg;
                dd_reg    <= g_reg;
                phase_reg <= 2'd2;
            end
        end
        if (cmd.fin)
        begin
            res_reg.status <= early_reg ? est_reg : ST_OK;
            res_reg.order  <= early_reg ? eord_reg : ORD_LESS;
            if (early_reg)
            begin
                res_reg.res_num <= '0;
                res_reg.res_den <= 31'd1;
            end
            else
            begin
                res_reg.res_num <= 32'(neg_reg ? -$signed({1'b0, qn_reg})
                                               : $signed({1'b0, qn_reg}));
                res_reg.res_den <= 31'(dq_reg);
            end
        end
    end

    assign sts.mul_done  = (mcnt_reg == 2'd3);
    assign sts.early     = early_reg;
    assign sts.div_done  = (dcnt_reg == CW'(WORD_BITS));
    assign sts.gcd_zero  = (dr_reg == '0);
    assign sts.red_phase = (phase_reg == 2'd1);
    assign res = res_reg;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit
// Rational arithmetic unit: one request (command plus two fractions) is taken
// when the block is idle; it forms exact cross products on a single shared
// 32x32 multiplier, checks for zero denominators and range overflow, then
// reduces the result with a Euclidean GCD built on one bit-serial divider,
// followed by two more divisions by the GCD. Compare, errors and a zero
// numerator skip the reduction. The next request is taken only once the
// result has left and the block is idle. The result is held until taken.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  rau_req_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output rau_res_t out_data
);

    rau_cmd_t cmd;
    rau_sts_t sts;

    // sequencer
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic
    rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
        .clk (clk),
        .req (in_data),
        .cmd (cmd),
        .sts (sts),
        .res (out_data)
    );

    // no new request taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("request accepted while result pending");

    // a result appears only in the cycle after the final build step
    assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(cmd.fin))
        else $error("result without final step");

    // failed requests carry a zero numerator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.res_num == '0)
        else $error("error result with nonzero numerator");

endmodule
